// ----- src/olde_pkg.sv -----
// Shared types and constants for the ordered list deque engine.
// No dependencies; the sequencer, top level and testbench refer to it by scoped names.
package olde_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;
  localparam int HELD_W    = 6;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd2;
  localparam logic [OP_W-1:0] OP_LIST_FWD  = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST_BWD  = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_LIST   = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

endpackage

// ----- src/olde_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies. Read data holds while rd_en is low.
module olde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/olde_seq.sv -----
// Sequencer of the deque engine: list pointers, count, search/shift/list walk
// over the entry RAM, and the output register. Depends on olde_pkg.
module olde_seq #(
  parameter int DEPTH  = olde_pkg::DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [olde_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [olde_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [olde_pkg::STAT_W-1:0]         out_status,
  output logic signed [olde_pkg::DATA_W-1:0]  out_entry_value,
  output logic                                out_last,
  output logic [olde_pkg::HELD_W-1:0]         out_entries_held,
  output logic                                mem_wr_en,
  output logic [IDX_W-1:0]                    mem_wr_addr,
  output logic [olde_pkg::DATA_W-1:0]         mem_wr_data,
  output logic                                mem_rd_en,
  output logic [IDX_W-1:0]                    mem_rd_addr,
  input  logic [olde_pkg::DATA_W-1:0]         mem_rd_data
);

  olde_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]                  front_r, front_nxt;
  logic [IDX_W-1:0]                  back_r, back_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [IDX_W-1:0]                  pos_r, pos_nxt;
  logic [IDX_W-1:0]                  k_r, k_nxt;
  logic                              fwd_r, fwd_nxt;
  logic [olde_pkg::DATA_W-1:0]       val_r, val_nxt;
  logic [olde_pkg::STAT_W-1:0]       res_status_r, res_status_nxt;

  logic                              out_valid_r;
  logic [olde_pkg::STAT_W-1:0]       out_status_r;
  logic [olde_pkg::DATA_W-1:0]       out_entry_value_r;
  logic                              out_last_r;
  logic [olde_pkg::HELD_W-1:0]       out_entries_held_r;

  logic                              load_out;
  logic [olde_pkg::STAT_W-1:0]       ld_status;
  logic [olde_pkg::DATA_W-1:0]       ld_value;
  logic                              ld_last;

  logic                              slot_free;
  logic [CNT_W-1:0]                  k_plus1;
  logic [CNT_W-1:0]                  k_plus2;
  logic                              last_k;
  logic [IDX_W-1:0]                  pos_inc;
  logic [IDX_W-1:0]                  pos_step;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    idx_inc = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    idx_dec = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign in_ready  = (state_r == olde_pkg::S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign k_plus1   = CNT_W'(k_r) + CNT_W'(1);
  assign k_plus2   = CNT_W'(k_r) + CNT_W'(2);
  assign last_k    = (k_plus1 == count_r);
  assign pos_inc   = idx_inc(pos_r);
  assign pos_step  = fwd_r ? pos_inc : idx_dec(pos_r);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    fwd_nxt        = fwd_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = pos_r;
    mem_wr_data    = mem_rd_data;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = pos_r;
    load_out       = 1'b0;
    ld_status      = olde_pkg::ST_OK;
    ld_value       = '0;
    ld_last        = 1'b1;

    unique case (state_r)
      olde_pkg::S_IDLE: begin
        if (in_valid) begin
          val_nxt = in_value;
          k_nxt   = '0;
          unique case (in_opcode)
            olde_pkg::OP_INS_FRONT, olde_pkg::OP_INS_BACK: begin
              if (count_r == CNT_W'(DEPTH)) begin
                res_status_nxt = olde_pkg::ST_FULL;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_data = in_value;
                if (count_r == '0) begin
                  mem_wr_addr = front_r;
                  back_nxt    = front_r;
                end else if (in_opcode == olde_pkg::OP_INS_FRONT) begin
                  mem_wr_addr = idx_dec(front_r);
                  front_nxt   = idx_dec(front_r);
                end else begin
                  mem_wr_addr = idx_inc(back_r);
                  back_nxt    = idx_inc(back_r);
                end
                count_nxt      = count_r + CNT_W'(1);
                res_status_nxt = olde_pkg::ST_OK;
              end
              state_nxt = olde_pkg::S_RESP;
            end
            olde_pkg::OP_DELETE: begin
              if (count_r == '0) begin
                res_status_nxt = olde_pkg::ST_EMPTY;
                state_nxt      = olde_pkg::S_RESP;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = front_r;
                pos_nxt     = front_r;
                state_nxt   = olde_pkg::S_SEARCH;
              end
            end
            olde_pkg::OP_LIST_FWD, olde_pkg::OP_LIST_BWD: begin
              if (count_r == '0) begin
                res_status_nxt = olde_pkg::ST_EMPTY;
                state_nxt      = olde_pkg::S_RESP;
              end else begin
                fwd_nxt     = (in_opcode == olde_pkg::OP_LIST_FWD);
                mem_rd_en   = 1'b1;
                mem_rd_addr = (in_opcode == olde_pkg::OP_LIST_FWD) ? front_r : back_r;
                pos_nxt     = (in_opcode == olde_pkg::OP_LIST_FWD) ? front_r : back_r;
                state_nxt   = olde_pkg::S_LIST;
              end
            end
            default: ;
          endcase
        end
      end

      olde_pkg::S_SEARCH: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = pos_inc;
        if (mem_rd_data == val_r) begin
          if (last_k) begin
            count_nxt = count_r - CNT_W'(1);
            if (count_r != CNT_W'(1)) begin
              back_nxt = idx_dec(back_r);
            end
            res_status_nxt = olde_pkg::ST_OK;
            state_nxt      = olde_pkg::S_RESP;
          end else begin
            state_nxt = olde_pkg::S_SHIFT;
          end
        end else if (last_k) begin
          res_status_nxt = olde_pkg::ST_NOTFOUND;
          state_nxt      = olde_pkg::S_RESP;
        end else begin
          pos_nxt = pos_inc;
          k_nxt   = k_r + 1'b1;
        end
      end

      olde_pkg::S_SHIFT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r;
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = idx_inc(pos_inc);
        pos_nxt     = pos_inc;
        k_nxt       = k_r + 1'b1;
        if (k_plus2 == count_r) begin
          count_nxt      = count_r - CNT_W'(1);
          back_nxt       = idx_dec(back_r);
          res_status_nxt = olde_pkg::ST_OK;
          state_nxt      = olde_pkg::S_RESP;
        end
      end

      olde_pkg::S_LIST: begin
        if (slot_free) begin
          load_out  = 1'b1;
          ld_status = olde_pkg::ST_OK;
          ld_value  = mem_rd_data;
          ld_last   = last_k;
          if (last_k) begin
            state_nxt = olde_pkg::S_IDLE;
          end else begin
            pos_nxt     = pos_step;
            k_nxt       = k_r + 1'b1;
            mem_rd_en   = 1'b1;
            mem_rd_addr = pos_step;
          end
        end
      end

      olde_pkg::S_RESP: begin
        if (slot_free) begin
          load_out  = 1'b1;
          ld_status = res_status_r;
          state_nxt = olde_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = olde_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olde_pkg::S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    k_r          <= k_nxt;
    fwd_r        <= fwd_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    if (load_out) begin
      out_status_r       <= ld_status;
      out_entry_value_r  <= ld_value;
      out_last_r         <= ld_last;
      out_entries_held_r <= olde_pkg::HELD_W'(count_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_value  = out_entry_value_r;
  assign out_last         = out_last_r;
  assign out_entries_held = out_entries_held_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_nonlast_is_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |->
      (out_status_r == olde_pkg::ST_OK && state_r == olde_pkg::S_LIST))
    else $error("non-final beat outside a listing");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olde_pkg::S_IDLE && in_valid &&
     (in_opcode == olde_pkg::OP_INS_FRONT || in_opcode == olde_pkg::OP_INS_BACK) &&
     count_r != CNT_W'(DEPTH)) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_list_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == olde_pkg::S_LIST) |-> !mem_wr_en)
    else $error("store written during a listing");

endmodule

// ----- src/ordered_list_deque_engine_top.sv -----
// Ordered list deque engine: top level. Instantiates the entry RAM and the
// sequencer. Depends on olde_pkg, olde_ram and olde_seq.
//
// Keeps an ordered list of up to DEPTH signed 32-bit values in a circular
// store with front and back pointers. Each input beat is one operation:
// insert at front, insert at back, delete the first entry (from the front)
// equal to the value, list front to back, or list back to front. Inserts and
// deletes answer with one beat; a listing sends one beat per held entry with
// last set on the final one, or a single "empty" beat. Unused opcodes are
// taken and dropped without a result. The block handles one operation at a
// time and drops in_ready while it works. All walks go through the single
// read port of the entry RAM, one entry per cycle unless the consumer stalls
// a listing: an insert writes its entry as it is accepted, a delete searches
// from the front and then shifts the entries behind the hit to close the
// gap, and a listing waits whenever the consumer stalls. The result
// register frees the sequencer as soon as a beat is loaded. The store is
// neither cleared nor initialized; only held entries are ever used.
module ordered_list_deque_engine_top #(
  parameter int DEPTH = olde_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [olde_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [olde_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [olde_pkg::STAT_W-1:0]         out_status,
  output logic signed [olde_pkg::DATA_W-1:0]  out_entry_value,
  output logic                                out_last,
  output logic [olde_pkg::HELD_W-1:0]         out_entries_held
);

  localparam int IDX_W = $clog2(DEPTH);

  // Entry RAM port: one write and one registered read per cycle
  logic                         mem_wr_en;
  logic [IDX_W-1:0]             mem_wr_addr;
  logic [olde_pkg::DATA_W-1:0]  mem_wr_data;
  logic                         mem_rd_en;
  logic [IDX_W-1:0]             mem_rd_addr;
  logic [olde_pkg::DATA_W-1:0]  mem_rd_data;

  olde_ram #(
    .WIDTH (olde_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Sequencer: pointers, count, search/shift/list walks and the result beat
  olde_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_value  (out_entry_value),
    .out_last         (out_last),
    .out_entries_held (out_entries_held),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data),
    .mem_rd_en        (mem_rd_en),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data)
  );

endmodule

// ----- tb/ordered_list_deque_engine_top_tb.sv -----
// Self-checking testbench for ordered_list_deque_engine_top: a shadow deque predicts every
// result beat, and a clocked driver and monitor exercise the valid/ready channels.
// Depends on olde_pkg and the engine RTL only.
module ordered_list_deque_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LIST_DEPTH   = olde_pkg::DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          PRINT_CAP    = 40;

  // Unused opcodes: the block takes them and answers with nothing.
  localparam logic [olde_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [olde_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [olde_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  typedef struct {
    logic [olde_pkg::OP_W-1:0]   op;
    logic [olde_pkg::DATA_W-1:0] value;
  } deque_req_t;

  typedef struct {
    logic [olde_pkg::STAT_W-1:0] status;
    logic [olde_pkg::DATA_W-1:0] entry;
    logic                        last;
    logic [olde_pkg::HELD_W-1:0] held;
  } deque_beat_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [olde_pkg::OP_W-1:0]           in_opcode = '0;
  logic signed [olde_pkg::DATA_W-1:0]  in_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [olde_pkg::STAT_W-1:0]         out_status;
  logic signed [olde_pkg::DATA_W-1:0]  out_entry_value;
  logic                                out_last;
  logic [olde_pkg::HELD_W-1:0]         out_entries_held;

  ordered_list_deque_engine_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_value  (out_entry_value),
    .out_last         (out_last),
    .out_entries_held (out_entries_held)
  );

  // Shadow of the deque: circular store, front/back pointers and entry count.
  logic [olde_pkg::DATA_W-1:0] shadow_store [LIST_DEPTH];
  int unsigned                 shadow_front = 0;
  int unsigned                 shadow_back  = 0;
  int unsigned                 shadow_count = 0;

  deque_req_t   pending_reqs [$];
  deque_beat_t  expected_beats [$];

  pace_t        pace = PACE_FULL;
  logic         rx_hold = 1'b0;
  bit           in_took = 1'b0;
  int           error_count = 0;
  int unsigned  cycle_count = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic log_mismatch(string what, logic [olde_pkg::DATA_W-1:0] got,
                              logic [olde_pkg::DATA_W-1:0] want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("[%0t] MISMATCH %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
    end
  endtask

  function automatic void push_beat(logic [olde_pkg::STAT_W-1:0] status,
                                    logic [olde_pkg::DATA_W-1:0] entry, logic last);
    deque_beat_t b;
    b.status = status;
    b.entry  = entry;
    b.last   = last;
    b.held   = olde_pkg::HELD_W'(shadow_count);
    expected_beats.push_back(b);
  endfunction

  // Apply one operation to the shadow deque and queue the beats it produces.
  function automatic void apply_deque_op(logic [olde_pkg::OP_W-1:0] op,
                                         logic [olde_pkg::DATA_W-1:0] value);
    int unsigned pos;
    int unsigned hit;
    case (op)
      olde_pkg::OP_INS_FRONT, olde_pkg::OP_INS_BACK: begin
        if (shadow_count >= LIST_DEPTH) begin
          push_beat(olde_pkg::ST_FULL, '0, 1'b1);
          return;
        end
        if (shadow_count == 0) begin
          // empty list: the entry lands at the front slot, back follows it
          shadow_back = shadow_front;
          shadow_store[shadow_front] = value;
        end else if (op == olde_pkg::OP_INS_FRONT) begin
          shadow_front = (shadow_front + LIST_DEPTH - 1) % LIST_DEPTH;
          shadow_store[shadow_front] = value;
        end else begin
          shadow_back = (shadow_back + 1) % LIST_DEPTH;
          shadow_store[shadow_back] = value;
        end
        shadow_count++;
        push_beat(olde_pkg::ST_OK, '0, 1'b1);
      end
      olde_pkg::OP_DELETE: begin
        if (shadow_count == 0) begin
          push_beat(olde_pkg::ST_EMPTY, '0, 1'b1);
          return;
        end
        pos = shadow_front;
        for (hit = 0; hit < shadow_count; hit++) begin
          if (shadow_store[pos] == value) break;
          pos = (pos + 1) % LIST_DEPTH;
        end
        if (hit == shadow_count) begin
          push_beat(olde_pkg::ST_NOTFOUND, '0, 1'b1);
          return;
        end
        // close the gap: everything behind the hit moves one slot toward the front
        for (int unsigned k = hit; k + 1 < shadow_count; k++) begin
          shadow_store[pos] = shadow_store[(pos + 1) % LIST_DEPTH];
          pos = (pos + 1) % LIST_DEPTH;
        end
        shadow_count--;
        if (shadow_count != 0) shadow_back = (shadow_back + LIST_DEPTH - 1) % LIST_DEPTH;
        push_beat(olde_pkg::ST_OK, '0, 1'b1);
      end
      olde_pkg::OP_LIST_FWD, olde_pkg::OP_LIST_BWD: begin
        if (shadow_count == 0) begin
          push_beat(olde_pkg::ST_EMPTY, '0, 1'b1);
          return;
        end
        pos = (op == olde_pkg::OP_LIST_FWD) ? shadow_front : shadow_back;
        for (int unsigned k = 0; k < shadow_count; k++) begin
          push_beat(olde_pkg::ST_OK, shadow_store[pos], k + 1 == shadow_count);
          pos = (op == olde_pkg::OP_LIST_FWD) ? (pos + 1) % LIST_DEPTH
                                              : (pos + LIST_DEPTH - 1) % LIST_DEPTH;
        end
      end
      default: ;
    endcase
  endfunction

  // Input side: predict on every accepted beat and tell the driver it went through.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      apply_deque_op(in_opcode, in_value);
      in_took = 1'b1;
    end
  end

  // Driver: change inputs on the falling edge. Hold valid and payload until the beat
  // is taken, then either offer the next request or drop valid and idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (pending_reqs.size() != 0 &&
          $urandom_range(99) >= ((pace == PACE_SEND_IDLE) ? 71 :
                                 (pace == PACE_BOTH) ? 9 : 0)) begin
        in_valid  <= 1'b1;
        in_opcode <= pending_reqs[0].op;
        in_value  <= pending_reqs[0].value;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure: random stalls by pace, plus the long hold-off when asked.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !rx_hold &&
                   ($urandom_range(99) >= ((pace == PACE_RECV_STALL) ? 71 :
                                           (pace == PACE_BOTH) ? 9 : 0));
    end
  end

  // Monitor: compare each result beat with the oldest expectation, field by field.
  always @(posedge clk) begin
    deque_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        log_mismatch("unexpected beat, entry_value", $unsigned(out_entry_value), '0);
      end else begin
        want = expected_beats.pop_front();
        if (out_status !== want.status)
          log_mismatch("status", olde_pkg::DATA_W'(out_status),
                       olde_pkg::DATA_W'(want.status));
        if ($unsigned(out_entry_value) !== want.entry)
          log_mismatch("entry_value", $unsigned(out_entry_value), want.entry);
        if (out_last !== want.last)
          log_mismatch("last", olde_pkg::DATA_W'(out_last), olde_pkg::DATA_W'(want.last));
        if (out_entries_held !== want.held)
          log_mismatch("entries_held", olde_pkg::DATA_W'(out_entries_held),
                       olde_pkg::DATA_W'(want.held));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_req(logic [olde_pkg::OP_W-1:0] op,
                           logic [olde_pkg::DATA_W-1:0] value);
    deque_req_t r;
    r.op    = op;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  // Block until every request went in and every expected beat came back.
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
  endtask

  // Values: mostly a small signed pool so deletes hit and duplicates appear,
  // otherwise full-range patterns and the two signed extremes.
  function automatic logic [olde_pkg::DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return olde_pkg::DATA_W'($signed($urandom_range(7)) - 3);
    if (r < 90) return $urandom;
    return (r < 95) ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // Random traffic: n real operations plus a sprinkle of unused opcodes.
  task automatic queue_random(int n, int ins_weight);
    int          issued;
    int unsigned r;
    issued = 0;
    while (issued < n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        queue_req(olde_pkg::OP_W'($urandom_range(7, 5)), $urandom);
        continue;
      end
      if (r < 4 + ins_weight)
        queue_req(($urandom_range(1) != 0) ? olde_pkg::OP_INS_FRONT : olde_pkg::OP_INS_BACK,
                  pick_value());
      else if (r < 19 + ins_weight)
        queue_req(($urandom_range(1) != 0) ? olde_pkg::OP_LIST_FWD : olde_pkg::OP_LIST_BWD,
                  $urandom);
      else
        queue_req(olde_pkg::OP_DELETE, pick_value());
      issued++;
    end
  endtask

  initial begin
    logic [olde_pkg::DATA_W-1:0] fill_vals [$];
    logic [olde_pkg::DATA_W-1:0] tmp;
    int unsigned                 j;

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-list answers, extremes, duplicates, every delete position,
    // delete down to empty and reuse after it, and the spare opcodes.
    pace = PACE_FULL;
    queue_req(olde_pkg::OP_LIST_FWD,  32'h0);
    queue_req(olde_pkg::OP_LIST_BWD,  32'hFFFF_FFFF);
    queue_req(olde_pkg::OP_DELETE,    32'h5);
    queue_req(olde_pkg::OP_INS_BACK,  32'h7FFF_FFFF);
    queue_req(olde_pkg::OP_INS_FRONT, 32'h8000_0000);
    queue_req(olde_pkg::OP_INS_BACK,  32'h0);
    queue_req(olde_pkg::OP_INS_FRONT, 32'hFFFF_FFFF);
    queue_req(olde_pkg::OP_INS_BACK,  32'h1);
    queue_req(olde_pkg::OP_INS_BACK,  32'h0);
    queue_req(olde_pkg::OP_LIST_FWD,  32'h0);
    queue_req(olde_pkg::OP_LIST_BWD,  32'h0);
    queue_req(olde_pkg::OP_DELETE,    32'h0001_2345);
    queue_req(olde_pkg::OP_DELETE,    32'h0);          // first of two zeros, mid-list
    queue_req(olde_pkg::OP_DELETE,    32'h0);          // now the back entry
    queue_req(olde_pkg::OP_DELETE,    32'hFFFF_FFFF);  // front entry
    queue_req(OP_SPARE_5,             32'hAAAA_AAAA);
    queue_req(OP_SPARE_6,             32'h5555_5555);
    queue_req(OP_SPARE_7,             32'hFFFF_FFFF);
    queue_req(olde_pkg::OP_LIST_FWD,  32'h0);
    queue_req(olde_pkg::OP_DELETE,    32'h7FFF_FFFF);
    queue_req(olde_pkg::OP_DELETE,    32'h1);
    queue_req(olde_pkg::OP_DELETE,    32'h8000_0000);  // list goes empty
    queue_req(olde_pkg::OP_LIST_BWD,  32'h0);
    queue_req(olde_pkg::OP_INS_FRONT, 32'h5555_5555);
    queue_req(olde_pkg::OP_DELETE,    32'h5555_5555);
    wait_quiet();

    // Pressure: hold the receiver off for a long stretch while the sender keeps
    // pushing inserts past full, then both listings of a full deque.
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < LIST_DEPTH + 4; i++) begin
      tmp = $urandom;
      if (i < LIST_DEPTH) fill_vals.push_back(tmp);
      queue_req(($urandom_range(1) != 0) ? olde_pkg::OP_INS_FRONT : olde_pkg::OP_INS_BACK,
                tmp);
    end
    queue_req(olde_pkg::OP_LIST_FWD, $urandom);
    queue_req(olde_pkg::OP_LIST_BWD, $urandom);
    wait_quiet();

    // Drain the full deque in shuffled order so deletes hit front, back and middle.
    pace = PACE_RECV_STALL;
    for (int i = fill_vals.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = fill_vals[i];
      fill_vals[i] = fill_vals[j];
      fill_vals[j] = tmp;
    end
    foreach (fill_vals[i]) begin
      queue_req(olde_pkg::OP_DELETE, fill_vals[i]);
      if ($urandom_range(7) == 0) queue_req(olde_pkg::OP_LIST_FWD, $urandom);
    end
    queue_req(olde_pkg::OP_LIST_FWD, $urandom);
    wait_quiet();

    // Random phases: one per pace, alternating insert-heavy and delete-heavy mixes.
    pace = PACE_FULL;
    queue_random(20, 60);
    wait_quiet();
    pace = PACE_SEND_IDLE;
    queue_random(20, 30);
    wait_quiet();
    pace = PACE_RECV_STALL;
    queue_random(20, 65);
    wait_quiet();
    pace = PACE_BOTH;
    queue_random(20, 35);
    wait_quiet();

    // Let any late or stray beat show up before judging.
    pace = PACE_FULL;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/olde_pkg.sv
src/olde_ram.sv
src/olde_seq.sv
src/ordered_list_deque_engine_top.sv
tb/ordered_list_deque_engine_top_tb.sv
